// ===== sv/tty_pkg.sv =====
`timescale 1ns / 1ps

package tty_pkg;

    // Widths of the result fields as seen on the output channel.
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Control bytes recognized by the cursor logic.
    localparam logic [7:0] CH_BEL = 8'd7;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    typedef struct packed {
        logic                 cell_write;
        logic [ROW_OUT_W-1:0] cell_row;
        logic [COL_OUT_W-1:0] cell_col;
        logic [7:0]           cell_char;
        logic                 clear_row;
        logic [ROW_OUT_W-1:0] clear_row_index;
        logic [ROW_OUT_W-1:0] cursor_row_out;
        logic [COL_OUT_W-1:0] cursor_col_out;
        logic [ROW_OUT_W-1:0] scroll_out;
        logic                 beep;
    } tty_result_t;

endpackage

// ===== sv/tty_if.sv =====
`timescale 1ns / 1ps

interface tty_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tty_out_if;
    logic                          valid;
    logic                          ready;
    logic                          cell_write;
    logic [tty_pkg::ROW_OUT_W-1:0] cell_row;
    logic [tty_pkg::COL_OUT_W-1:0] cell_col;
    logic [7:0]                    cell_char;
    logic                          clear_row;
    logic [tty_pkg::ROW_OUT_W-1:0] clear_row_index;
    logic [tty_pkg::ROW_OUT_W-1:0] cursor_row_out;
    logic [tty_pkg::COL_OUT_W-1:0] cursor_col_out;
    logic [tty_pkg::ROW_OUT_W-1:0] scroll_out;
    logic                          beep;

    modport source (
        output valid, output cell_write, output cell_row, output cell_col,
        output cell_char, output clear_row, output clear_row_index,
        output cursor_row_out, output cursor_col_out, output scroll_out,
        output beep, input ready
    );
    modport sink (
        input valid, input cell_write, input cell_row, input cell_col,
        input cell_char, input clear_row, input clear_row_index,
        input cursor_row_out, input cursor_col_out, input scroll_out,
        input beep, output ready
    );
endinterface

// ===== sv/tty_terminal_cursor_engine.sv =====
`timescale 1ns / 1ps

// Character handler for a plain terminal: each request carries one received
// byte and yields exactly one registered result in the cycle after it is
// accepted: the cell to write (if any), the ring row to clear after a scroll
// (if any), the new cursor and the scroll offset. A new byte is taken every
// cycle while results are taken; the only loop is the cursor state, updated
// by compare and increment logic. While a result waits the input is held off,
// and a new byte is accepted in the same cycle that the waiting result is
// taken. auto_wrap resets to 1; the user writes it through cfg_wr_en and
// cfg_wr_data while the block is idle, which the block does not enforce.
module tty_terminal_cursor_engine #(
    parameter int COLS      = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    tty_in_if.sink    rx,
    tty_out_if.source res
);

    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int PH_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [ROW_W-1:0]     scroll_reg;
    logic [ROW_W-1:0]     scroll_next;
    logic [PH_W-1:0]      phase_reg;
    logic [PH_W-1:0]      phase_next;
    logic                 auto_wrap_reg;
    logic                 res_valid_reg;
    tty_pkg::tty_result_t result_next;
    tty_pkg::tty_result_t result_reg;
    logic                 accept;

    assign rx.ready = !res_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    tty_cursor_step #(
        .COLS      (COLS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_step (
        .rx_byte     (rx.rx_byte),
        .auto_wrap   (auto_wrap_reg),
        .col         (col_reg),
        .row         (row_reg),
        .scroll      (scroll_reg),
        .phase       (phase_reg),
        .col_next    (col_next),
        .row_next    (row_next),
        .scroll_next (scroll_next),
        .phase_next  (phase_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            scroll_reg    <= '0;
            phase_reg     <= '0;
            auto_wrap_reg <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                auto_wrap_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                scroll_reg <= scroll_next;
                phase_reg  <= phase_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.cell_write      = result_reg.cell_write;
    assign res.cell_row        = result_reg.cell_row;
    assign res.cell_col        = result_reg.cell_col;
    assign res.cell_char       = result_reg.cell_char;
    assign res.clear_row       = result_reg.clear_row;
    assign res.clear_row_index = result_reg.clear_row_index;
    assign res.cursor_row_out  = result_reg.cursor_row_out;
    assign res.cursor_col_out  = result_reg.cursor_col_out;
    assign res.scroll_out      = result_reg.scroll_out;
    assign res.beep            = result_reg.beep;

endmodule

// ===== sv/tty_cursor_step.sv =====
`timescale 1ns / 1ps

module tty_cursor_step #(
    parameter int COLS      = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic [7:0]                               rx_byte,
    input  logic                                     auto_wrap,
    input  logic [$clog2(COLS)-1:0]                  col,
    input  logic [$clog2(ROWS)-1:0]                  row,
    input  logic [$clog2(ROWS)-1:0]                  scroll,
    input  logic [((TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1)-1:0] phase,
    output logic [$clog2(COLS)-1:0]                  col_next,
    output logic [$clog2(ROWS)-1:0]                  row_next,
    output logic [$clog2(ROWS)-1:0]                  scroll_next,
    output logic [((TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1)-1:0] phase_next,
    output tty_pkg::tty_result_t                     result
);

    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int PH_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int SUM_W = $clog2(COLS + TAB_WIDTH + 1);

    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]  PHASE_LAST = PH_W'(TAB_WIDTH - 1);

    logic [ROW_W:0]    phys_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [SUM_W-1:0]  tab_stop;
    logic              tab_ok;
    logic              lf_req;
    logic              scroll_up;
    logic              write_en;

    // Physical row of the cursor in the ring: both terms stay below ROWS.
    assign phys_sum = {1'b0, row} + {1'b0, scroll};
    assign phys_row = (phys_sum >= (ROW_W + 1)'(ROWS)) ?
                      ROW_W'(phys_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(phys_sum);

    // The phase register holds col mod TAB_WIDTH, so the next stop needs no divide.
    // Taking the tab is allowed exactly when the next stop still lies on the line.
    assign tab_stop = SUM_W'(col) + SUM_W'(TAB_WIDTH) - SUM_W'(phase);
    assign tab_ok   = tab_stop <= SUM_W'(COLS - 1);

    always_comb
    begin
        col_next   = col;
        phase_next = phase;
        lf_req     = 1'b0;
        write_en   = 1'b0;
        unique case (rx_byte)
            tty_pkg::CH_BEL:
            begin
            end
            tty_pkg::CH_BS:
            begin
                if (col != '0)
                begin
                    col_next   = col - 1'b1;
                    phase_next = (phase == '0) ? PHASE_LAST : phase - 1'b1;
                end
            end
            tty_pkg::CH_TAB:
            begin
                if (tab_ok)
                begin
                    col_next   = COL_W'(tab_stop);
                    phase_next = '0;
                end
            end
            tty_pkg::CH_CR:
            begin
                col_next   = '0;
                phase_next = '0;
            end
            tty_pkg::CH_LF:
            begin
                lf_req = 1'b1;
            end
            default:
            begin
                write_en = 1'b1;
                if (col != COL_LAST)
                begin
                    col_next   = col + 1'b1;
                    phase_next = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
                end
                else if (auto_wrap)
                begin
                    col_next   = '0;
                    phase_next = '0;
                    lf_req     = 1'b1;
                end
            end
        endcase
    end

    // A line feed on the bottom row scrolls the ring; the row to clear is the
    // one that was at the top before the scroll.
    assign scroll_up   = lf_req && (row == ROW_LAST);
    assign row_next    = (lf_req && !scroll_up) ? row + 1'b1 : row;
    assign scroll_next = !scroll_up ? scroll :
                         (scroll == ROW_LAST) ? '0 : scroll + 1'b1;

    always_comb
    begin
        result.cell_write      = write_en;
        result.cell_row        = write_en ? tty_pkg::ROW_OUT_W'(phys_row) : '0;
        result.cell_col        = write_en ? tty_pkg::COL_OUT_W'(col) : '0;
        result.cell_char       = write_en ? rx_byte : 8'd0;
        result.clear_row       = scroll_up;
        result.clear_row_index = scroll_up ? tty_pkg::ROW_OUT_W'(scroll) : '0;
        result.cursor_row_out  = tty_pkg::ROW_OUT_W'(row_next);
        result.cursor_col_out  = tty_pkg::COL_OUT_W'(col_next);
        result.scroll_out      = tty_pkg::ROW_OUT_W'(scroll_next);
        result.beep            = (rx_byte == tty_pkg::CH_BEL);
    end

endmodule

// ===== tb/tty_cursor_checker.sv =====
`timescale 1ns / 1ps

module tty_cursor_checker #(
    parameter int COLS      = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    tty_in_if    rx,
    tty_out_if   res,
    output int   errors,
    output int   pending,
    output int   results,
    output int   scrolls,
    output int   wraps
);

    int                   cur_col;
    int                   cur_row;
    int                   scroll_pos;
    logic                 wrap_on;
    tty_pkg::tty_result_t cursor_q[$];

    initial
    begin
        errors = 0;
        pending = 0;
        results = 0;
        scrolls = 0;
        wraps = 0;
        cur_col = 0;
        cur_row = 0;
        scroll_pos = 0;
        wrap_on = 1'b1;
    end

    // Moves the cursor down one line; on the bottom row the ring advances
    // and the row that becomes the bottom line is returned for clearing.
    function automatic logic line_down(output logic [tty_pkg::ROW_OUT_W-1:0] cleared);
        cleared = '0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
            return 1'b0;
        end
        scroll_pos = (scroll_pos + 1) % ROWS;
        cleared = tty_pkg::ROW_OUT_W'((ROWS - 1 + scroll_pos) % ROWS);
        scrolls++;
        return 1'b1;
    endfunction

    function automatic tty_pkg::tty_result_t next_cursor(input logic [7:0] ch);
        tty_pkg::tty_result_t           r;
        logic [tty_pkg::ROW_OUT_W-1:0]  idx;
        r = '0;
        case (ch)
            tty_pkg::CH_BEL: r.beep = 1'b1;
            tty_pkg::CH_BS:
                if (cur_col > 0)
                    cur_col--;
            tty_pkg::CH_TAB:
                if (cur_col / TAB_WIDTH < (COLS - 1) / TAB_WIDTH)
                    cur_col += TAB_WIDTH - cur_col % TAB_WIDTH;
            tty_pkg::CH_CR: cur_col = 0;
            tty_pkg::CH_LF:
            begin
                r.clear_row = line_down(idx);
                r.clear_row_index = idx;
            end
            default:
            begin
                r.cell_write = 1'b1;
                r.cell_row = tty_pkg::ROW_OUT_W'((cur_row + scroll_pos) % ROWS);
                r.cell_col = tty_pkg::COL_OUT_W'(cur_col);
                r.cell_char = ch;
                cur_col++;
                if (cur_col >= COLS)
                begin
                    if (wrap_on)
                    begin
                        cur_col = 0;
                        wraps++;
                        r.clear_row = line_down(idx);
                        r.clear_row_index = idx;
                    end
                    else
                    begin
                        cur_col = COLS - 1;
                    end
                end
            end
        endcase
        r.cursor_row_out = tty_pkg::ROW_OUT_W'(cur_row);
        r.cursor_col_out = tty_pkg::COL_OUT_W'(cur_col);
        r.scroll_out = tty_pkg::ROW_OUT_W'(scroll_pos);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tty_pkg::tty_result_t want;
        tty_pkg::tty_result_t got;
        if (!rst_n)
        begin
            cur_col = 0;
            cur_row = 0;
            scroll_pos = 0;
            wrap_on = 1'b1;
            cursor_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                wrap_on = cfg_wr_data;
            if (rx.valid && rx.ready)
                cursor_q.push_back(next_cursor(rx.rx_byte));
            if (res.valid && res.ready)
            begin
                results++;
                if (cursor_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request outstanding", $time);
                end
                else
                begin
                    want = cursor_q.pop_front();
                    got.cell_write = res.cell_write;
                    got.cell_row = res.cell_row;
                    got.cell_col = res.cell_col;
                    got.cell_char = res.cell_char;
                    got.clear_row = res.clear_row;
                    got.clear_row_index = res.clear_row_index;
                    got.cursor_row_out = res.cursor_row_out;
                    got.cursor_col_out = res.cursor_col_out;
                    got.scroll_out = res.scroll_out;
                    got.beep = res.beep;
                    check_field("cell_write", 8'(want.cell_write), 8'(got.cell_write));
                    check_field("cell_row", 8'(want.cell_row), 8'(got.cell_row));
                    check_field("cell_col", 8'(want.cell_col), 8'(got.cell_col));
                    check_field("cell_char", want.cell_char, got.cell_char);
                    check_field("clear_row", 8'(want.clear_row), 8'(got.clear_row));
                    check_field("clear_row_index", 8'(want.clear_row_index),
                                8'(got.clear_row_index));
                    check_field("cursor_row_out", 8'(want.cursor_row_out),
                                8'(got.cursor_row_out));
                    check_field("cursor_col_out", 8'(want.cursor_col_out),
                                8'(got.cursor_col_out));
                    check_field("scroll_out", 8'(want.scroll_out), 8'(got.scroll_out));
                    check_field("beep", 8'(want.beep), 8'(got.beep));
                end
            end
            pending = cursor_q.size();
        end
    end

endmodule

// ===== tb/tty_terminal_cursor_engine_test.sv =====
`timescale 1ns / 1ps

module tty_terminal_cursor_engine_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    int   fail_count;
    int   pending;
    int   result_count;
    int   scroll_count;
    int   wrap_count;
    int   sent_count = 0;
    bit   calm = 1'b0;
    bit   choked = 1'b0;

    tty_in_if  in_ch ();
    tty_out_if out_ch ();

    tty_terminal_cursor_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (in_ch),
        .res         (out_ch)
    );

    tty_cursor_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (in_ch),
        .res         (out_ch),
        .errors      (fail_count),
        .pending     (pending),
        .results     (result_count),
        .scrolls     (scroll_count),
        .wraps       (wrap_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit with %0d results pending", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random ready bursts, plus one long hold-off once the run is
    // under way so that the block backs up and stalls its input.
    initial
    begin : receiver
        int span;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!choked && sent_count >= 150)
            begin
                choked = 1'b1;
                out_ch.ready <= 1'b0;
                span = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                span = $urandom_range(1, 10);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                span = $urandom_range(1, 20);
            end
            repeat (span) @(posedge clk);
        end
    end

    task automatic send(input logic [7:0] b);
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] control_byte();
        case ($urandom_range(0, 4))
            0: return tty_pkg::CH_BEL;
            1: return tty_pkg::CH_BS;
            2: return tty_pkg::CH_TAB;
            3: return tty_pkg::CH_LF;
            default: return tty_pkg::CH_CR;
        endcase
    endfunction

    // The register only changes once every outstanding request has drained.
    task automatic set_wrap(input logic wrap);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= wrap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int target);
        while (sent_count < target)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    // Tab out to the last zone and write up to, and sometimes past, the end of the line.
                    send(tty_pkg::CH_CR);
                    repeat (9) send(tty_pkg::CH_TAB);
                    repeat ($urandom_range(4, 12)) send(8'($urandom_range(0, 255)));
                end
                1: repeat ($urandom_range(5, 30)) send(tty_pkg::CH_LF);
                2, 3:
                    repeat ($urandom_range(3, 15))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send(control_byte());
                        else
                            send(8'($urandom_range(0, 255)));
                    end
                4:
                begin
                    repeat ($urandom_range(1, 10)) send(tty_pkg::CH_BS);
                    repeat ($urandom_range(1, 10)) send(8'($urandom_range(0, 255)));
                end
                default: repeat ($urandom_range(10, 85)) send(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.rx_byte = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bell, backspace at column 0, extreme and high bytes, tabs into the
        // last zone, then writes through the last column so the line wraps.
        send(tty_pkg::CH_BEL);
        send(8'h00);
        send(tty_pkg::CH_BS);
        send(tty_pkg::CH_BS);
        send(8'hFF);
        send(8'h80);
        send(tty_pkg::CH_CR);
        repeat (9) send(tty_pkg::CH_TAB);
        send(tty_pkg::CH_TAB);
        send(8'h7F);
        send(8'h55);
        send(8'hAA);
        send(8'h20);
        send(8'h01);
        send(8'hFE);
        send(8'h0B);
        send(8'h41);
        send(tty_pkg::CH_LF);

        run_random(320);
        set_wrap(1'b0);
        run_random(620);
        set_wrap(1'b1);
        run_random(780);
        calm = 1'b1;
        run_random(920);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes and checked %0d results: %0d ring scrolls, %0d line wraps,",
                 sent_count, result_count, scroll_count, wrap_count);
        $display("with auto-wrap both off and on and one long result-side stall.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
